FILE: hw/rtl/assert_macros.svh
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/chte_pkg.sv
// ----------------------------------------------------------------------------
// chte_pkg
// shared constants, types and the tabulation hash rom function
// ----------------------------------------------------------------------------
package chte_pkg;

    localparam int TABLE_COUNT_DEF = 3;
    localparam int INDEX_BITS_DEF  = 10;
    localparam int KEY_BITS_DEF    = 64;
    localparam int VALUE_BITS_DEF  = 32;
    localparam int TRIALS_BITS     = 7;
    localparam int FAIL_BITS       = 16;
    localparam int TAG_BITS        = 8;
    localparam int PORT_KEY_BITS   = 64;
    localparam int PORT_VAL_BITS   = 32;
    localparam logic [TRIALS_BITS-1:0] TRIALS_RESET = 7'd8;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture a new item
        logic hash_step;  // run one hash bit step
        logic hash_clear; // reset hash accumulators
        logic clear;      // write one empty slot per table after reset
        logic wr_upd;     // rewrite values of matching slots
        logic wr_ins;     // write carried entry into free slot
        logic wr_evict;   // swap carried entry with victim
        logic take_vic;   // carried entry becomes the victim data
        logic fail;       // bump failure counter
        logic set_ok;     // record success
        logic show;       // latch result
    } chte_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clear_done;
        logic hash_done;
        logic hit;
        logic any_free;
        logic is_update;
        logic trials_zero;
        logic trials_last;
    } chte_sts_t;

    // splitmix64 low bits, evaluated at elaboration for the constant rom
    function automatic logic [63:0] splitmix64(input logic [63:0] x);
        logic [63:0] z;
        z = x + 64'h9E3779B97F4A7C15;
        z = (z ^ (z >> 30)) * 64'hBF58476D1CE4E5B9;
        z = (z ^ (z >> 27)) * 64'h94D049BB133111EB;
        return z ^ (z >> 31);
    endfunction

endpackage

FILE: hw/rtl/chte_ram.sv
// ----------------------------------------------------------------------------
// chte_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module chte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // registered read, returns the old word on a write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: hw/rtl/chte_datapath.sv
// ----------------------------------------------------------------------------
// chte_datapath
// hash units, table memories, carried entry and result registers
// ----------------------------------------------------------------------------
module chte_datapath #(
    parameter int TABLE_COUNT = chte_pkg::TABLE_COUNT_DEF,
    parameter int INDEX_BITS  = chte_pkg::INDEX_BITS_DEF,
    parameter int KEY_BITS    = chte_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = chte_pkg::VALUE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  chte_pkg::chte_cmd_t               cmd,
    output chte_pkg::chte_sts_t               sts,
    input  logic                              cfg_we,
    input  logic [chte_pkg::TRIALS_BITS-1:0]  cfg_data,
    input  logic                              in_op,
    input  logic [chte_pkg::PORT_KEY_BITS-1:0] in_key,
    input  logic [chte_pkg::PORT_VAL_BITS-1:0] in_v1,
    input  logic [chte_pkg::PORT_VAL_BITS-1:0] in_v2,
    input  logic [chte_pkg::TAG_BITS-1:0]     in_tag,
    output logic                              out_hit,
    output logic [chte_pkg::PORT_VAL_BITS-1:0] out_f1,
    output logic [chte_pkg::PORT_VAL_BITS-1:0] out_f2,
    output logic                              out_ok,
    output logic [chte_pkg::FAIL_BITS-1:0]    out_fail,
    output logic [chte_pkg::TAG_BITS-1:0]     out_tag
);
    import chte_pkg::*;

    localparam int SLOTS   = 1 << INDEX_BITS;
    localparam int KCW     = $clog2(KEY_BITS + 1);
    localparam int KIW     = $clog2(KEY_BITS);
    localparam int TW      = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
    localparam int ENTRY   = 1 + KEY_BITS + 2 * VALUE_BITS;
    localparam int DIVISOR = TABLE_COUNT - 1;
    localparam int RSH     = INDEX_BITS + 3;
    localparam int RMUL    = ((1 << RSH) + DIVISOR - 1) / DIVISOR;

    // constant tabulation rom, one word per (table, bit value, bit position)
    function automatic logic [INDEX_BITS-1:0] rom_word(input int t, input int b,
                                                       input int k);
        logic [63:0] z;
        z = splitmix64(64'((t * 2 + b) * KEY_BITS + k));
        return z[INDEX_BITS-1:0];
    endfunction

    logic [INDEX_BITS-1:0] rom0 [TABLE_COUNT][KEY_BITS];
    logic [INDEX_BITS-1:0] rom1 [TABLE_COUNT][KEY_BITS];
    for (genvar gt = 0; gt < TABLE_COUNT; gt++)
    begin : g_rom_t
        for (genvar gk = 0; gk < KEY_BITS; gk++)
        begin : g_rom_k
            assign rom0[gt][gk] = rom_word(gt, 0, gk);
            assign rom1[gt][gk] = rom_word(gt, 1, gk);
        end
    end

    // item and carried entry registers
    logic                     op_reg;
    logic [TAG_BITS-1:0]      tag_reg;
    logic [KEY_BITS-1:0]      ck_reg;
    logic [VALUE_BITS-1:0]    c1_reg, c2_reg;
    logic [TRIALS_BITS-1:0]   trials_reg;
    logic [TRIALS_BITS-1:0]   round_reg;
    logic [TW-1:0]            vidx_reg;
    logic                     toggle_reg;
    logic [FAIL_BITS-1:0]     fail_reg;
    logic                     ok_reg;
    logic [KCW-1:0]           kbit_reg;
    logic [INDEX_BITS-1:0]    h_reg [TABLE_COUNT];
    logic [INDEX_BITS-1:0]    clr_reg;

    // memory read data, entry = {valid, v2, v1, key}
    logic [ENTRY-1:0]         rd_data [TABLE_COUNT];
    logic [TABLE_COUNT-1:0]   match_vec, free_vec;
    logic [TW-1:0]            match_t, free_t, victim_t;
    logic [INDEX_BITS-1:0]    h_vidx;
    logic [INDEX_BITS+RSH:0]  vprod;
    logic [INDEX_BITS-1:0]    vquot, vrem;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trials_reg <= TRIALS_RESET;
        end
        else if (cfg_we)
        begin
            trials_reg <= cfg_data;
        end
    end

    // match, free and victim selection from registered reads
    always_comb
    begin
        match_t = '0;
        free_t  = '0;
        for (int t = 0; t < TABLE_COUNT; t++)
        begin
            match_vec[t] = rd_data[t][ENTRY-1] &&
                           (rd_data[t][KEY_BITS-1:0] == ck_reg);
            free_vec[t]  = !rd_data[t][ENTRY-1];
            if (match_vec[t])
            begin
                match_t = TW'(t);
            end
            if (free_vec[t])
            begin
                free_t = TW'(t);
            end
        end
        // victim: hash modulo (tables - 1) by reciprocal multiply, plus toggle
        h_vidx   = h_reg[vidx_reg];
        vprod    = (INDEX_BITS+RSH+1)'(h_vidx) * (INDEX_BITS+RSH+1)'(RMUL);
        vquot    = vprod[RSH +: INDEX_BITS];
        vrem     = h_vidx - vquot * INDEX_BITS'(DIVISOR);
        victim_t = TW'(vrem) + TW'(toggle_reg);
    end

    // table memories, one per table
    for (genvar gt = 0; gt < TABLE_COUNT; gt++)
    begin : g_tab
        logic                  we;
        logic [INDEX_BITS-1:0] ad;
        logic [ENTRY-1:0]      wd;
        always_comb
        begin
            we = 1'b0;
            ad = h_reg[gt];
            wd = {1'b1, c2_reg, c1_reg, ck_reg};
            if (cmd.clear)
            begin
                we = 1'b1;
                ad = clr_reg;
                wd = '0;
            end
            if (cmd.wr_upd && match_vec[gt])
            begin
                we = 1'b1;
            end
            if (cmd.wr_ins && free_t == TW'(gt))
            begin
                we = 1'b1;
            end
            if (cmd.wr_evict && victim_t == TW'(gt))
            begin
                we = 1'b1;
            end
        end
        chte_ram #(.WIDTH(ENTRY), .DEPTH(SLOTS)) u_ram (
            .clk   (clk),
            .we    (we),
            .addr  (ad),
            .wdata (wd),
            .rdata (rd_data[gt])
        );

        // bit-serial hash accumulator
        always_ff @(posedge clk)
        begin
            if (cmd.hash_clear)
            begin
                h_reg[gt] <= '0;
            end
            else if (cmd.hash_step)
            begin
                h_reg[gt] <= h_reg[gt] ^ (ck_reg[kbit_reg[KIW-1:0]]
                             ? rom1[gt][kbit_reg[KIW-1:0]] : rom0[gt][kbit_reg[KIW-1:0]]);
            end
        end
    end

    // clearing pass address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // hash bit counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kbit_reg <= '0;
        end
        else if (cmd.hash_clear)
        begin
            kbit_reg <= '0;
        end
        else if (cmd.hash_step)
        begin
            kbit_reg <= kbit_reg + 1'b1;
        end
    end

    // carried entry, rounds, toggle, failure counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            toggle_reg <= 1'b0;
            fail_reg   <= '0;
            round_reg  <= '0;
            vidx_reg   <= '0;
            ok_reg     <= 1'b0;
            op_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                op_reg    <= in_op;
                round_reg <= '0;
                vidx_reg  <= '0;
                ok_reg    <= 1'b0;
            end
            if (cmd.set_ok)
            begin
                ok_reg <= 1'b1;
            end
            if (cmd.wr_ins || cmd.wr_evict)
            begin
                toggle_reg <= ~toggle_reg;
                round_reg  <= round_reg + 1'b1;
            end
            if (cmd.wr_evict)
            begin
                vidx_reg <= (vidx_reg == TW'(TABLE_COUNT - 1)) ? '0 : vidx_reg + 1'b1;
            end
            if (cmd.fail)
            begin
                fail_reg <= fail_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ck_reg  <= in_key[KEY_BITS-1:0];
            c1_reg  <= VALUE_BITS'(in_v1);
            c2_reg  <= VALUE_BITS'(in_v2);
            tag_reg <= in_tag;
        end
        else if (cmd.take_vic)
        begin
            {c2_reg, c1_reg, ck_reg} <= rd_data[victim_t][ENTRY-2:0];
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.show)
        begin
            out_hit  <= |match_vec;
            out_f1   <= '0;
            out_f2   <= '0;
            if (op_reg == OP_LOOKUP && |match_vec)
            begin
                out_f1 <= PORT_VAL_BITS'(rd_data[match_t][KEY_BITS +: VALUE_BITS]);
                out_f2 <= PORT_VAL_BITS'(rd_data[match_t][KEY_BITS+VALUE_BITS +: VALUE_BITS]);
            end
            out_tag  <= tag_reg;
        end
    end

    assign out_ok   = ok_reg;
    assign out_fail = fail_reg;

    // status to controller
    always_comb
    begin
        sts.clear_done  = (clr_reg == '1);
        sts.hash_done   = (kbit_reg == KCW'(KEY_BITS));
        sts.hit         = |match_vec;
        sts.any_free    = |free_vec;
        sts.is_update   = (op_reg == OP_UPDATE);
        sts.trials_zero = (trials_reg == '0);
        sts.trials_last = (round_reg + 1'b1 >= trials_reg);
    end
endmodule

FILE: hw/rtl/chte_ctrl.sv
// ----------------------------------------------------------------------------
// chte_ctrl
// sequencer for lookup, update and cuckoo insert rounds
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module chte_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  chte_pkg::chte_sts_t sts,
    output chte_pkg::chte_cmd_t cmd
);
    import chte_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_HASH, ST_READ, ST_WAIT, ST_DECIDE,
        ST_IHASH, ST_IREAD, ST_IWAIT, ST_IDECIDE, ST_SWAP, ST_OUT
    } state_t;

    state_t state_reg, state_next;

    // command decode
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_done) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    cmd.load       = 1'b1;
                    cmd.hash_clear = 1'b1;
                    state_next     = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (sts.hash_done) state_next = ST_READ;
                else cmd.hash_step = 1'b1;
            end
            ST_READ:   state_next = ST_WAIT;
            ST_WAIT:   state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                cmd.show = 1'b1;
                if (!sts.is_update)
                begin
                    state_next = ST_OUT;
                end
                else if (sts.hit)
                begin
                    cmd.wr_upd = 1'b1;
                    cmd.set_ok = 1'b1;
                    state_next = ST_OUT;
                end
                else if (sts.trials_zero)
                begin
                    cmd.fail   = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_IREAD;
                end
            end
            ST_IHASH:
            begin
                if (sts.hash_done) state_next = ST_IREAD;
                else cmd.hash_step = 1'b1;
            end
            ST_IREAD:  state_next = ST_IWAIT;
            ST_IWAIT:  state_next = ST_IDECIDE;
            ST_IDECIDE:
            begin
                if (sts.any_free)
                begin
                    cmd.wr_ins = 1'b1;
                    cmd.set_ok = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.wr_evict = 1'b1;
                    cmd.take_vic = 1'b1;
                    state_next   = ST_SWAP;
                    if (sts.trials_last)
                    begin
                        cmd.fail   = 1'b1;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_SWAP:
            begin
                cmd.hash_clear = 1'b1;
                state_next     = ST_IHASH;
            end
            ST_OUT:
            begin
                if (m_ready) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    `ASSERT_ALWAYS(a_excl, clk, rst_n, !(s_ready && m_valid))
    `ASSERT_ALWAYS(a_one_write, clk, rst_n,
        $countones({cmd.wr_upd, cmd.wr_ins, cmd.wr_evict}) <= 1)
    `ASSERT_NEXT(a_load_hash, clk, rst_n, cmd.load, state_reg == ST_HASH)
    `ASSERT_ALWAYS(a_clear_quiet, clk, rst_n, !(cmd.clear && (s_ready || m_valid)))
endmodule

FILE: hw/rtl/cuckoo_hash_table_engine_unit.sv
// ----------------------------------------------------------------------------
// cuckoo_hash_table_engine_unit
// cuckoo hash key-value store with tabulation hashing
// ----------------------------------------------------------------------------
// One transaction at a time. After reset a clearing pass writes every slot of
// every table empty, with s_tready low. Each hash steps one key bit per cycle
// through the tabulation rom, all tables in parallel, and then sees the bit
// count done, followed by the read, wait and decide states. An insert reuses
// the key's hash for its first round, and every further eviction round
// rehashes the carried entry, up to the trial limit.
module cuckoo_hash_table_engine_unit #(
    parameter int TABLE_COUNT = chte_pkg::TABLE_COUNT_DEF,
    parameter int INDEX_BITS  = chte_pkg::INDEX_BITS_DEF,
    parameter int KEY_BITS    = chte_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = chte_pkg::VALUE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_data,   // trial limit
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,    // opcode, key, value_first, value_second, source_tag
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata     // hit, found_first, found_second, insert_ok, failures, source_echo
);
    import chte_pkg::*;

    chte_cmd_t cmd;
    chte_sts_t sts;
    logic                     o_hit, o_ok;
    logic [PORT_VAL_BITS-1:0] o_f1, o_f2;
    logic [FAIL_BITS-1:0]     o_fail;
    logic [TAG_BITS-1:0]      o_tag;

    // controller
    chte_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .s_valid(s_tvalid), .s_ready(s_tready),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .sts(sts), .cmd(cmd)
    );

    // datapath
    chte_datapath #(
        .TABLE_COUNT(TABLE_COUNT), .INDEX_BITS(INDEX_BITS),
        .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_op(s_tdata[0]), .in_key(s_tdata[64:1]),
        .in_v1(s_tdata[96:65]), .in_v2(s_tdata[128:97]), .in_tag(s_tdata[136:129]),
        .out_hit(o_hit), .out_f1(o_f1), .out_f2(o_f2),
        .out_ok(o_ok), .out_fail(o_fail), .out_tag(o_tag)
    );

    // output packing, padded to whole bytes
    assign m_tdata = {6'b0, o_tag, o_fail, o_ok, o_f2, o_f1, o_hit};
endmodule

FILE: tb/sv/cuckoo_hash_table_engine_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cuckoo_hash_table_engine_unit_checker
// Watches both stream channels and the trials register port. It keeps its own
// copy of the three hashed tables and of the tabulation rom, works out the
// result of every accepted request, and compares each accepted response with
// the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module cuckoo_hash_table_engine_unit_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [95:0]  m_tdata,
    output int           pending,
    output int           error_count
);
    import chte_pkg::*;

    localparam int NT    = 3;
    localparam int NIDX  = 10;
    localparam int NKEY  = 64;
    localparam int NSLOT = 1 << NIDX;

    // last member sits in the lowest bits, matching the bus order
    typedef struct packed {
        logic [7:0]  source_echo;
        logic [15:0] failures;
        logic        insert_ok;
        logic [31:0] found_second;
        logic [31:0] found_first;
        logic        hit;
    } lookup_result_t;

    typedef logic [NT-1:0][NIDX-1:0] slot_index_t;

    logic [NIDX-1:0] tab_rom [0:2*NT*NKEY-1];
    logic            entry_used  [0:NT*NSLOT-1];
    logic [63:0]     entry_key   [0:NT*NSLOT-1];
    logic [31:0]     entry_first [0:NT*NSLOT-1];
    logic [31:0]     entry_second[0:NT*NSLOT-1];
    logic            toggle_bit;
    logic [15:0]     lost_inserts;
    logic [6:0]      trial_limit;
    lookup_result_t  expected_q[$];

    // splitmix64 scrambler used to fill the tabulation rom
    function automatic logic [63:0] scramble64(input logic [63:0] x);
        logic [63:0] z;
        z = x + 64'h9E3779B97F4A7C15;
        z = (z ^ (z >> 30)) * 64'hBF58476D1CE4E5B9;
        z = (z ^ (z >> 27)) * 64'h94D049BB133111EB;
        return z ^ (z >> 31);
    endfunction

    // one bucket index per table, XOR of one rom word per key bit
    function automatic slot_index_t bucket_of(input logic [63:0] key);
        slot_index_t h;
        for (int t = 0; t < NT; t++)
        begin
            h[t] = '0;
            for (int k = 0; k < NKEY; k++)
                h[t] ^= tab_rom[(t * 2 + key[k]) * NKEY + k];
        end
        return h;
    endfunction

    // full behavior of one request, updates the shadow tables
    function automatic lookup_result_t serve_request(input logic [143:0] d);
        lookup_result_t r;
        slot_index_t    h;
        logic           op;
        logic [63:0]    key;
        logic [31:0]    v1;
        logic [31:0]    v2;
        logic [63:0]    ck;
        logic [63:0]    sk;
        logic [31:0]    c1;
        logic [31:0]    c2;
        logic [31:0]    s1;
        logic [31:0]    s2;
        int             match;
        int             free_t;
        int             vidx;
        int             vt;
        int             a;
        op  = d[0];
        key = d[64:1];
        v1  = d[96:65];
        v2  = d[128:97];
        r   = '0;
        r.source_echo = d[136:129];
        h     = bucket_of(key);
        match = -1;
        for (int t = 0; t < NT; t++)
        begin
            a = t * NSLOT + h[t];
            if (entry_used[a] && entry_key[a] == key)
                match = t;
        end
        r.hit = (match >= 0);
        if (op == OP_LOOKUP)
        begin
            if (r.hit)
            begin
                a = match * NSLOT + h[match];
                r.found_first  = entry_first[a];
                r.found_second = entry_second[a];
            end
        end
        else if (r.hit)
        begin
            // rewrite values of every table holding the key
            for (int t = 0; t < NT; t++)
            begin
                a = t * NSLOT + h[t];
                if (entry_used[a] && entry_key[a] == key)
                begin
                    entry_first[a]  = v1;
                    entry_second[a] = v2;
                end
            end
            r.insert_ok = 1'b1;
        end
        else
        begin
            // eviction rounds with a carried entry
            ck   = key;
            c1   = v1;
            c2   = v2;
            vidx = 0;
            for (int rnd = 0; rnd < trial_limit && !r.insert_ok; rnd++)
            begin
                h      = bucket_of(ck);
                free_t = -1;
                for (int t = 0; t < NT; t++)
                    if (!entry_used[t * NSLOT + h[t]])
                        free_t = t;
                if (free_t >= 0)
                begin
                    a = free_t * NSLOT + h[free_t];
                    entry_used[a]   = 1'b1;
                    entry_key[a]    = ck;
                    entry_first[a]  = c1;
                    entry_second[a] = c2;
                    r.insert_ok     = 1'b1;
                end
                else
                begin
                    vt = (h[vidx] % (NT - 1)) + toggle_bit;
                    a  = vt * NSLOT + h[vt];
                    sk = entry_key[a];
                    s1 = entry_first[a];
                    s2 = entry_second[a];
                    entry_key[a]    = ck;
                    entry_first[a]  = c1;
                    entry_second[a] = c2;
                    ck = sk;
                    c1 = s1;
                    c2 = s2;
                    vidx = (vidx == NT - 1) ? 0 : vidx + 1;
                end
                toggle_bit = ~toggle_bit;
            end
            if (!r.insert_ok)
                lost_inserts = lost_inserts + 16'd1;
        end
        r.failures = lost_inserts;
        return r;
    endfunction

    initial
    begin
        logic [63:0] z;
        for (int n = 0; n < 2 * NT * NKEY; n++)
        begin
            z = scramble64(64'(n));
            tab_rom[n] = z[NIDX-1:0];
        end
    end

    // watch the channels
    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t e;
        lookup_result_t g;
        if (!rst_n)
        begin
            for (int i = 0; i < NT * NSLOT; i++)
                entry_used[i] = 1'b0;
            toggle_bit   = 1'b0;
            lost_inserts = '0;
            trial_limit  = TRIALS_RESET;
            error_count  = 0;
            expected_q.delete();
            pending      = 0;
        end
        else
        begin
            if (cfg_we)
                trial_limit = cfg_data;
            // response transaction
            if (m_tvalid && m_tready)
            begin
                g = m_tdata[89:0];
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected response %h", $time, m_tdata);
                    error_count++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (g.hit !== e.hit || g.found_first !== e.found_first ||
                        g.found_second !== e.found_second ||
                        g.insert_ok !== e.insert_ok || g.failures !== e.failures ||
                        g.source_echo !== e.source_echo)
                    begin
                        $display("%0t: mismatch expected hit=%b f1=%h f2=%h ok=%b fail=%0d tag=%h",
                                 $time, e.hit, e.found_first, e.found_second, e.insert_ok,
                                 e.failures, e.source_echo);
                        $display("%0t:          actual   hit=%b f1=%h f2=%h ok=%b fail=%0d tag=%h",
                                 $time, g.hit, g.found_first, g.found_second, g.insert_ok,
                                 g.failures, g.source_echo);
                        error_count++;
                    end
                end
            end
            // request transaction
            if (s_tvalid && s_tready)
                expected_q.push_back(serve_request(s_tdata));
            pending = expected_q.size();
        end
    end

endmodule

FILE: tb/sv/cuckoo_hash_table_engine_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cuckoo_hash_table_engine_unit_test
// Drives lookups, updates and inserts with random gaps and response stalls,
// steps the trials register through its extremes while idle, and reports the
// verdict from the checker's error count.
// ----------------------------------------------------------------------------
module cuckoo_hash_table_engine_unit_test;
    import chte_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int KEY_POOL    = 256;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [6:0]   cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;    // opcode, key, value_first, value_second, source_tag
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;    // hit, found_first, found_second, insert_ok, failures, source_echo
    int           pending;
    int           error_count;
    int           cycle_count;
    bit           idle_off;
    bit           long_hold;
    logic [63:0]  key_pool[KEY_POOL];

    cuckoo_hash_table_engine_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cuckoo_hash_table_engine_unit_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .pending     (pending),
        .error_count (error_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // response side: random stalls, one long hold on request
    initial
    begin
        int gap;
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = idle_off ? 0 : $urandom_range(0, 9);
            if (long_hold && !held)
            begin
                gap  = 600;
                held = 1'b1;
            end
            @(negedge clk);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // one request transaction
    task automatic send_req(input logic op, input logic [63:0] key,
                            input logic [31:0] v1, input logic [31:0] v2);
        int gap;
        gap = idle_off ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {7'b0, 8'($urandom), v2, v1, key, op};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // quiet the request side until every response is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic set_trials(input logic [6:0] n);
        drain();
        cfg_data <= n;
        cfg_we   <= 1'b1;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic random_phase(input int count, input int update_pct);
        logic [63:0] k;
        logic        op;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 70)
                k = key_pool[$urandom_range(0, KEY_POOL - 1)];
            else
                k = {$urandom, $urandom};
            op = ($urandom_range(0, 99) < update_pct) ? OP_UPDATE : OP_LOOKUP;
            if (i % 97 == 40)
                idle_off = ~idle_off;
            send_req(op, k, $urandom, $urandom);
        end
    endtask

    initial
    begin
        cycle_count = 0;
        idle_off    = 1'b0;
        long_hold   = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = {$urandom, $urandom};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty lookups, extremes, update hit, zero trials
        send_req(OP_LOOKUP, 64'h0, 32'h0, 32'h0);
        send_req(OP_UPDATE, 64'h0, 32'hFFFFFFFF, 32'h0);
        send_req(OP_UPDATE, '1, 32'h0, 32'hFFFFFFFF);
        send_req(OP_LOOKUP, 64'h0, 32'h0, 32'h0);
        send_req(OP_LOOKUP, '1, 32'h0, 32'h0);
        send_req(OP_UPDATE, 64'h0, 32'h12345678, 32'h9ABCDEF0);
        send_req(OP_LOOKUP, 64'h0, '1, '1);
        send_req(OP_UPDATE, 64'h5555_5555_5555_5555, '1, '1);
        send_req(OP_UPDATE, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0, 32'h0);
        send_req(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0, 32'h0);
        set_trials(7'd0);
        send_req(OP_UPDATE, 64'h1, 32'h1, 32'h1);
        send_req(OP_LOOKUP, 64'h1, 32'h0, 32'h0);
        send_req(OP_UPDATE, '1, 32'h7, 32'h7);
        send_req(OP_LOOKUP, '1, 32'h0, 32'h0);

        // fill and churn under several trial limits
        set_trials(7'd8);
        random_phase(300, 75);
        long_hold = 1'b1;
        random_phase(20, 50);
        set_trials(7'd1);
        random_phase(150, 60);
        set_trials(7'd64);
        random_phase(300, 70);
        set_trials(7'd127);
        random_phase(100, 60);
        set_trials(7'd0);
        random_phase(40, 50);
        set_trials(7'd3);
        random_phase(240, 50);

        drain();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
